@@ hdl/ldss_pkg.sv @@
`default_nettype none

package ldss_pkg;

   localparam int CONC_W  = 48;
   localparam int RATE_W  = 32;
   localparam int SUM_W   = 50;
   localparam int MAG_W   = 51;
   localparam int SEED_W  = 49;
   localparam int X_W     = 54;
   localparam int DEN_W   = 55;
   localparam int QUOT_W  = 33;
   localparam int GAIN_W  = 64;
   localparam int PART_W  = 58;
   localparam int ACC_W   = 115;
   localparam int DELTA_W = 58;
   localparam int CNT_W   = 3;

   localparam logic [CONC_W-1:0] CONC_MAX    = {CONC_W{1'b1}};
   localparam logic [CONC_W-1:0] FLOOR_RESET = 48'd1759;

   localparam int DIV_STEPS   = QUOT_W;
   localparam int ST_CAPTURE  = 0;
   localparam int ST_DIFF     = 1;
   localparam int ST_SQUARE   = 2;
   localparam int ST_X        = 3;
   localparam int ST_DEN      = 4;
   localparam int ST_DIV0     = 5;
   localparam int ST_GAINMUL  = ST_DIV0 + DIV_STEPS;
   localparam int ST_GAIN     = ST_GAINMUL + 1;
   localparam int ST_DMUL     = ST_GAIN + 1;
   localparam int ST_DACC     = ST_DMUL + 1;
   localparam int ST_DELTA    = ST_DACC + 1;
   localparam int ST_RAW      = ST_DELTA + 1;
   localparam int ST_CLAMP    = ST_RAW + 1;
   localparam int NUM_STAGES  = ST_CLAMP + 1;

   typedef enum logic [2:0] {
      REG_TIME_STEP,
      REG_CYTO_RATE,
      REG_STORE_RATE,
      REG_BUFFER_TOTAL,
      REG_BUFFER_HALF,
      REG_FLOOR
   } csr_index_type;

   typedef struct packed {
      logic [CONC_W-1:0] cy;
      logic [CONC_W-1:0] st;
   } cell_type;

   typedef struct packed {
      logic [RATE_W-1:0] time_step;
      logic [RATE_W-1:0] cyto_rate;
      logic [RATE_W-1:0] store_rate;
      logic [CONC_W-1:0] buffer_total;
      logic [CONC_W-1:0] buffer_half;
      logic [CONC_W-1:0] floor_level;
   } cfg_type;

   typedef struct packed {
      logic              valid;
      logic              last;
      logic              done;
      logic [CONC_W-1:0] ctr_cy;
      logic [CONC_W-1:0] ctr_st;
      logic [SUM_W-1:0]  sum_cy;
      logic [SUM_W-1:0]  sum_st;
      logic [CNT_W-1:0]  n;
   } task_type;

   typedef struct packed {
      logic                   last;
      logic                   done;
      logic [CONC_W-1:0]      ctr_cy;
      logic [CONC_W-1:0]      ctr_st;
      logic [SUM_W-1:0]       sum_cy;
      logic [SUM_W-1:0]       sum_st;
      logic [CNT_W-1:0]       n;
      logic                   up_cy;
      logic                   up_st;
      logic [MAG_W-1:0]       mag_cy;
      logic [MAG_W-1:0]       mag_st;
      logic [SEED_W-1:0]      seed;
      logic [GAIN_W-1:0]      pc;
      logic [GAIN_W-1:0]      ps;
      logic [49:0]            sq_ll;
      logic [48:0]            sq_hl;
      logic [47:0]            sq_hh;
      logic [X_W-1:0]         x;
      logic [DEN_W-1:0]       den;
      logic                   den_zero;
      logic [DEN_W-1:0]       rem;
      logic [QUOT_W-1:0]      quot;
      logic [GAIN_W-1:0]      gp_hi;
      logic [GAIN_W-1:0]      gp_lo;
      logic                   gain_full;
      logic [GAIN_W-1:0]      gc;
      logic [3:0][PART_W-1:0] dp_cy;
      logic [3:0][PART_W-1:0] dp_st;
      logic [1:0][ACC_W-1:0]  acc_cy;
      logic [1:0][ACC_W-1:0]  acc_st;
      logic [DELTA_W-1:0]     delta_cy;
      logic [DELTA_W-1:0]     delta_st;
      logic [CONC_W-1:0]      res_cy;
      logic [CONC_W-1:0]      res_st;
   } work_type;

   typedef struct packed {
      logic [CONC_W-1:0] cyto;
      logic [CONC_W-1:0] store;
      logic              last;
      logic              done;
   } result_type;

endpackage

`default_nettype wire

@@ hdl/ldss_window.sv @@
`default_nettype none

module ldss_window import ldss_pkg::*; #(
   parameter int ROW_LEN  = 16,
   parameter int NUM_ROWS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic [CONC_W-1:0] req_cyto_conc,
   input  wire logic [CONC_W-1:0] req_store_conc,
   output logic                   req_stall,
   input  wire logic              advance,
   output task_type               cell_task,
   output logic                   flushing
);

   localparam int COL_W    = (ROW_LEN > 1) ? $clog2(ROW_LEN) : 1;
   localparam int ROW_W    = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
   localparam int LINE_LEN = 2 * ROW_LEN;
   localparam int TAP_CTR  = ROW_LEN - 1;
   localparam int TAP_RT   = ROW_LEN - 2;
   localparam int TAP_LF   = ROW_LEN;
   localparam int TAP_UP   = 2 * ROW_LEN - 1;
   localparam logic [COL_W-1:0] COL_LAST = COL_W'(ROW_LEN - 1);
   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(NUM_ROWS - 1);

   cell_type          line_ff [LINE_LEN];
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [COL_W-1:0]  fcol_ff, fcol_in;
   logic              flush_ff, flush_in;

   logic              fire;
   logic              at_final;
   logic [COL_W-1:0]  pos;
   logic              has_up, has_down, has_left, has_right;
   cell_type          x;
   cell_type          nb_up, nb_dn, nb_lf, nb_rt;

   always_comb begin
      x.cy      = req_cyto_conc;
      x.st      = req_store_conc;
      fire      = advance && (req_valid || flush_ff);
      req_stall = flush_ff || !advance;
      flushing  = flush_ff;
      at_final  = (row_ff == ROW_LAST) && (col_ff == COL_LAST);
      pos       = flush_ff ? fcol_ff : col_ff;
      has_up    = flush_ff || (row_ff > ROW_W'(1));
      has_down  = !flush_ff;
      has_left  = (pos != '0);
      has_right = (pos != COL_LAST);

      nb_up = has_up    ? line_ff[TAP_UP] : '0;
      nb_dn = has_down  ? x               : '0;
      nb_lf = has_left  ? line_ff[TAP_LF] : '0;
      nb_rt = has_right ? line_ff[TAP_RT] : '0;

      cell_task.valid  = fire && (flush_ff || (row_ff != '0));
      cell_task.last   = flush_ff ? (pos == COL_LAST) : !at_final;
      cell_task.done   = flush_ff && (pos == COL_LAST);
      cell_task.ctr_cy = line_ff[TAP_CTR].cy;
      cell_task.ctr_st = line_ff[TAP_CTR].st;
      cell_task.sum_cy = (SUM_W'(nb_up.cy) + SUM_W'(nb_dn.cy))
                       + (SUM_W'(nb_lf.cy) + SUM_W'(nb_rt.cy));
      cell_task.sum_st = (SUM_W'(nb_up.st) + SUM_W'(nb_dn.st))
                       + (SUM_W'(nb_lf.st) + SUM_W'(nb_rt.st));
      cell_task.n      = CNT_W'(has_up) + CNT_W'(has_down)
                       + CNT_W'(has_left) + CNT_W'(has_right);
   end

   always_comb begin
      row_in   = row_ff;
      col_in   = col_ff;
      fcol_in  = fcol_ff;
      flush_in = flush_ff;
      if (fire) begin
         if (flush_ff) begin
            if (fcol_ff == COL_LAST) begin
               flush_in = 1'b0;
            end else begin
               fcol_in = fcol_ff + 1'b1;
            end
         end else if (at_final) begin
            row_in   = '0;
            col_in   = '0;
            fcol_in  = '0;
            flush_in = 1'b1;
         end else if (col_ff == COL_LAST) begin
            col_in = '0;
            row_in = row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff   <= '0;
         col_ff   <= '0;
         fcol_ff  <= '0;
         flush_ff <= 1'b0;
      end else begin
         row_ff   <= row_in;
         col_ff   <= col_in;
         fcol_ff  <= fcol_in;
         flush_ff <= flush_in;
      end
   end

   // shift in zeros while the last row drains
   always_ff @(posedge clock) begin
      if (fire) begin
         line_ff[0] <= flush_ff ? '0 : x;
         for (int k = 1; k < LINE_LEN; k++) begin
            line_ff[k] <= line_ff[k-1];
         end
      end
   end

endmodule

`default_nettype wire

@@ hdl/ldss_pipe.sv @@
`default_nettype none

module ldss_pipe import ldss_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire task_type          cell_task,
   input  wire cfg_type           cfg,
   output logic                   advance,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [CONC_W-1:0]      rsp_cyto_next,
   output logic [CONC_W-1:0]      rsp_store_next,
   output logic                   rsp_run_last,
   output logic                   rsp_frame_done
);

   logic [NUM_STAGES-1:0] v_ff, v_in;
   work_type              work_ff [NUM_STAGES];
   work_type              work_in [NUM_STAGES];

   logic [MAG_W-1:0]      base_cy, base_st;
   logic [97:0]           sq_full;
   logic [DEN_W:0]        div_trial [DIV_STEPS];
   logic                  div_bit [DIV_STEPS];
   logic [ACC_W-1:0]      total_cy, total_st;
   logic [CONC_W+10:0]    raw_cy, raw_st;

   result_type            stage_res;
   result_type            out_ff, skid_ff;
   logic                  out_v_ff, skid_v_ff;
   logic                  push, take;

   function automatic logic [MAG_W-1:0] times_n(input logic [CONC_W-1:0] c,
                                                input logic [CNT_W-1:0] n);
      logic [MAG_W-1:0] w;
      logic [MAG_W-1:0] r;
      w = MAG_W'(c);
      case (n)
         3'd1:    r = w;
         3'd2:    r = w << 1;
         3'd3:    r = w + (w << 1);
         3'd4:    r = w << 2;
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic [CONC_W-1:0] step_conc(input logic [CONC_W-1:0] c,
                                                   input logic up,
                                                   input logic [DELTA_W-1:0] d,
                                                   input logic [CONC_W+10:0] s);
      logic [CONC_W-1:0] r;
      if (up) begin
         r = (s > (CONC_W+11)'(CONC_MAX)) ? CONC_MAX : s[CONC_W-1:0];
      end else begin
         r = (d >= DELTA_W'(c)) ? '0 : c - d[CONC_W-1:0];
      end
      return r;
   endfunction

   always_comb begin
      v_in = {v_ff[NUM_STAGES-2:0], cell_task.valid};

      work_in[ST_CAPTURE]        = '0;
      work_in[ST_CAPTURE].last   = cell_task.last;
      work_in[ST_CAPTURE].done   = cell_task.done;
      work_in[ST_CAPTURE].ctr_cy = cell_task.ctr_cy;
      work_in[ST_CAPTURE].ctr_st = cell_task.ctr_st;
      work_in[ST_CAPTURE].sum_cy = cell_task.sum_cy;
      work_in[ST_CAPTURE].sum_st = cell_task.sum_st;
      work_in[ST_CAPTURE].n      = cell_task.n;
      for (int k = 1; k < NUM_STAGES; k++) begin
         work_in[k] = work_ff[k-1];
      end

      // laplacian magnitude and sign, buffer seed, rate products
      base_cy = times_n(work_ff[ST_DIFF-1].ctr_cy, work_ff[ST_DIFF-1].n);
      base_st = times_n(work_ff[ST_DIFF-1].ctr_st, work_ff[ST_DIFF-1].n);
      work_in[ST_DIFF].up_cy  = {1'b0, work_ff[ST_DIFF-1].sum_cy} >= base_cy;
      work_in[ST_DIFF].up_st  = {1'b0, work_ff[ST_DIFF-1].sum_st} >= base_st;
      work_in[ST_DIFF].mag_cy = work_in[ST_DIFF].up_cy
                              ? {1'b0, work_ff[ST_DIFF-1].sum_cy} - base_cy
                              : base_cy - {1'b0, work_ff[ST_DIFF-1].sum_cy};
      work_in[ST_DIFF].mag_st = work_in[ST_DIFF].up_st
                              ? {1'b0, work_ff[ST_DIFF-1].sum_st} - base_st
                              : base_st - {1'b0, work_ff[ST_DIFF-1].sum_st};
      work_in[ST_DIFF].seed   = SEED_W'(cfg.buffer_half)
                              + SEED_W'(work_ff[ST_DIFF-1].ctr_cy);
      work_in[ST_DIFF].pc     = GAIN_W'(cfg.time_step) * GAIN_W'(cfg.cyto_rate);
      work_in[ST_DIFF].ps     = GAIN_W'(cfg.time_step) * GAIN_W'(cfg.store_rate);

      // square of the seed in three partial products
      work_in[ST_SQUARE].sq_ll = 50'(work_ff[ST_SQUARE-1].seed[24:0])
                               * 50'(work_ff[ST_SQUARE-1].seed[24:0]);
      work_in[ST_SQUARE].sq_hl = 49'(work_ff[ST_SQUARE-1].seed[48:25])
                               * 49'(work_ff[ST_SQUARE-1].seed[24:0]);
      work_in[ST_SQUARE].sq_hh = 48'(work_ff[ST_SQUARE-1].seed[48:25])
                               * 48'(work_ff[ST_SQUARE-1].seed[48:25]);

      sq_full = (98'(work_ff[ST_X-1].sq_hh) << 50)
              + (98'(work_ff[ST_X-1].sq_hl) << 26)
              + 98'(work_ff[ST_X-1].sq_ll);
      work_in[ST_X].x = sq_full[97:44];

      work_in[ST_DEN].den      = DEN_W'(work_ff[ST_DEN-1].x)
                               + DEN_W'(cfg.buffer_total);
      work_in[ST_DEN].den_zero = (work_in[ST_DEN].den == '0);
      work_in[ST_DEN].rem      = DEN_W'(work_ff[ST_DEN-1].x[X_W-1:1]);
      work_in[ST_DEN].quot     = '0;

      // restoring divide, one quotient bit per stage
      for (int k = 0; k < DIV_STEPS; k++) begin
         div_bit[k]   = (k == 0) ? work_ff[ST_DIV0+k-1].x[0] : 1'b0;
         div_trial[k] = {work_ff[ST_DIV0+k-1].rem, div_bit[k]};
         if (div_trial[k] >= {1'b0, work_ff[ST_DIV0+k-1].den}) begin
            work_in[ST_DIV0+k].rem  = DEN_W'(div_trial[k]
                                    - {1'b0, work_ff[ST_DIV0+k-1].den});
            work_in[ST_DIV0+k].quot = {work_ff[ST_DIV0+k-1].quot[QUOT_W-2:0], 1'b1};
         end else begin
            work_in[ST_DIV0+k].rem  = div_trial[k][DEN_W-1:0];
            work_in[ST_DIV0+k].quot = {work_ff[ST_DIV0+k-1].quot[QUOT_W-2:0], 1'b0};
         end
      end

      work_in[ST_GAINMUL].gp_hi = GAIN_W'(work_ff[ST_GAINMUL-1].pc[63:32])
                                * GAIN_W'(work_ff[ST_GAINMUL-1].quot[31:0]);
      work_in[ST_GAINMUL].gp_lo = GAIN_W'(work_ff[ST_GAINMUL-1].pc[31:0])
                                * GAIN_W'(work_ff[ST_GAINMUL-1].quot[31:0]);
      work_in[ST_GAINMUL].gain_full = work_ff[ST_GAINMUL-1].den_zero
                                    || work_ff[ST_GAINMUL-1].quot[QUOT_W-1];

      work_in[ST_GAIN].gc = work_ff[ST_GAIN-1].gain_full
                          ? work_ff[ST_GAIN-1].pc
                          : work_ff[ST_GAIN-1].gp_hi
                            + GAIN_W'(work_ff[ST_GAIN-1].gp_lo[63:32]);

      // delta = mag * gain / 2^57 in four partial products
      work_in[ST_DMUL].dp_cy[0] = PART_W'(work_ff[ST_DMUL-1].mag_cy[25:0])
                                * PART_W'(work_ff[ST_DMUL-1].gc[31:0]);
      work_in[ST_DMUL].dp_cy[1] = PART_W'(work_ff[ST_DMUL-1].mag_cy[25:0])
                                * PART_W'(work_ff[ST_DMUL-1].gc[63:32]);
      work_in[ST_DMUL].dp_cy[2] = PART_W'(work_ff[ST_DMUL-1].mag_cy[50:26])
                                * PART_W'(work_ff[ST_DMUL-1].gc[31:0]);
      work_in[ST_DMUL].dp_cy[3] = PART_W'(work_ff[ST_DMUL-1].mag_cy[50:26])
                                * PART_W'(work_ff[ST_DMUL-1].gc[63:32]);
      work_in[ST_DMUL].dp_st[0] = PART_W'(work_ff[ST_DMUL-1].mag_st[25:0])
                                * PART_W'(work_ff[ST_DMUL-1].ps[31:0]);
      work_in[ST_DMUL].dp_st[1] = PART_W'(work_ff[ST_DMUL-1].mag_st[25:0])
                                * PART_W'(work_ff[ST_DMUL-1].ps[63:32]);
      work_in[ST_DMUL].dp_st[2] = PART_W'(work_ff[ST_DMUL-1].mag_st[50:26])
                                * PART_W'(work_ff[ST_DMUL-1].ps[31:0]);
      work_in[ST_DMUL].dp_st[3] = PART_W'(work_ff[ST_DMUL-1].mag_st[50:26])
                                * PART_W'(work_ff[ST_DMUL-1].ps[63:32]);

      work_in[ST_DACC].acc_cy[0] = ACC_W'(work_ff[ST_DACC-1].dp_cy[0])
                                 + (ACC_W'(work_ff[ST_DACC-1].dp_cy[1]) << 32);
      work_in[ST_DACC].acc_cy[1] = (ACC_W'(work_ff[ST_DACC-1].dp_cy[2]) << 26)
                                 + (ACC_W'(work_ff[ST_DACC-1].dp_cy[3]) << 58);
      work_in[ST_DACC].acc_st[0] = ACC_W'(work_ff[ST_DACC-1].dp_st[0])
                                 + (ACC_W'(work_ff[ST_DACC-1].dp_st[1]) << 32);
      work_in[ST_DACC].acc_st[1] = (ACC_W'(work_ff[ST_DACC-1].dp_st[2]) << 26)
                                 + (ACC_W'(work_ff[ST_DACC-1].dp_st[3]) << 58);

      total_cy = work_ff[ST_DELTA-1].acc_cy[0] + work_ff[ST_DELTA-1].acc_cy[1];
      total_st = work_ff[ST_DELTA-1].acc_st[0] + work_ff[ST_DELTA-1].acc_st[1];
      work_in[ST_DELTA].delta_cy = total_cy[ACC_W-1:57];
      work_in[ST_DELTA].delta_st = total_st[ACC_W-1:57];

      raw_cy = (CONC_W+11)'(work_ff[ST_RAW-1].ctr_cy)
             + (CONC_W+11)'(work_ff[ST_RAW-1].delta_cy);
      raw_st = (CONC_W+11)'(work_ff[ST_RAW-1].ctr_st)
             + (CONC_W+11)'(work_ff[ST_RAW-1].delta_st);
      work_in[ST_RAW].res_cy = step_conc(work_ff[ST_RAW-1].ctr_cy,
                                         work_ff[ST_RAW-1].up_cy,
                                         work_ff[ST_RAW-1].delta_cy, raw_cy);
      work_in[ST_RAW].res_st = step_conc(work_ff[ST_RAW-1].ctr_st,
                                         work_ff[ST_RAW-1].up_st,
                                         work_ff[ST_RAW-1].delta_st, raw_st);

      work_in[ST_CLAMP].res_cy = (work_ff[ST_CLAMP-1].res_cy < cfg.floor_level)
                               ? cfg.floor_level : work_ff[ST_CLAMP-1].res_cy;
      work_in[ST_CLAMP].res_st = (work_ff[ST_CLAMP-1].res_st < cfg.floor_level)
                               ? cfg.floor_level : work_ff[ST_CLAMP-1].res_st;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (advance) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            work_ff[k] <= work_in[k];
         end
      end
   end

   // output word plus skid entry
   always_comb begin
      stage_res.cyto  = work_ff[ST_CLAMP].res_cy;
      stage_res.store = work_ff[ST_CLAMP].res_st;
      stage_res.last  = work_ff[ST_CLAMP].last;
      stage_res.done  = work_ff[ST_CLAMP].done;
      advance         = !skid_v_ff;
      push            = advance && v_ff[ST_CLAMP];
      take            = out_v_ff && !rsp_stall;
      rsp_valid       = out_v_ff;
      rsp_cyto_next   = out_ff.cyto;
      rsp_store_next  = out_ff.store;
      rsp_run_last    = out_ff.last;
      rsp_frame_done  = out_ff.done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (take) begin
            skid_v_ff <= 1'b0;
         end
      end else if (push) begin
         if (out_v_ff && !take) begin
            skid_v_ff <= 1'b1;
         end else begin
            out_v_ff <= 1'b1;
         end
      end else if (take) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (take) begin
            out_ff <= skid_ff;
         end
      end else if (push) begin
         if (out_v_ff && !take) begin
            skid_ff <= stage_res;
         end else begin
            out_ff <= stage_res;
         end
      end
   end

endmodule

`default_nettype wire

@@ hdl/lattice_diffusion_stencil_step_core.sv @@
// Five-point diffusion half-step over a streamed ROW_LEN x NUM_ROWS grid.
// req channel: one cell per word (cytosolic and store concentration, UQ4.44)
// in raster order. rsp channel: updated cells, one row behind the input;
// row 0 words give no result. The last word of a frame is followed by a
// drain of ROW_LEN words for the last row, during which req_stall is high.
// run_last is high on each result from an input word but the frame's last one
// and on the last drain result; frame_done the result for the grid's last cell.
// Throughput: one word per cycle in and out, apart from the drain and rsp stalls.
// A result passes through the 45-stage pipeline (a 33-stage restoring divider for
// the buffering factor dominates) and then through the output register.
// A stalled rsp keeps its word; the pipeline runs on into a skid entry and
// holds only once that is full, so input words keep arriving meanwhile.
// Configuration goes through the csr port (64-bit data, register i at 8*i)
// and must be written only while the block is idle; the block does not enforce it.
// Reset clears the row and column counters, valid bits and the registers
// (floor to 1759); the line store is not cleared.
`default_nettype none

module lattice_diffusion_stencil_step_core import ldss_pkg::*; #(
   parameter int ROW_LEN  = 16,
   parameter int NUM_ROWS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [CONC_W-1:0] req_cyto_conc,
   input  wire logic [CONC_W-1:0] req_store_conc,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [CONC_W-1:0]      rsp_cyto_next,
   output logic [CONC_W-1:0]      rsp_store_next,
   output logic                   rsp_run_last,
   output logic                   rsp_frame_done,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [5:0]        csr_paddr,
   input  wire logic [63:0]       csr_pwdata,
   output logic [63:0]            csr_prdata,
   output logic                   csr_pready
);

   cfg_type       cfg_ff, cfg_in;
   csr_index_type csr_index;
   logic          csr_write;
   task_type      cell_task;
   logic          advance;
   logic          win_flushing;

   always_comb begin
      csr_pready = 1'b1;
      csr_index  = csr_index_type'(csr_paddr[5:3]);
      csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
      cfg_in     = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            REG_TIME_STEP:    cfg_in.time_step    = csr_pwdata[RATE_W-1:0];
            REG_CYTO_RATE:    cfg_in.cyto_rate    = csr_pwdata[RATE_W-1:0];
            REG_STORE_RATE:   cfg_in.store_rate   = csr_pwdata[RATE_W-1:0];
            REG_BUFFER_TOTAL: cfg_in.buffer_total = csr_pwdata[CONC_W-1:0];
            REG_BUFFER_HALF:  cfg_in.buffer_half  = csr_pwdata[CONC_W-1:0];
            REG_FLOOR:        cfg_in.floor_level  = csr_pwdata[CONC_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_TIME_STEP:    csr_prdata = 64'(cfg_ff.time_step);
         REG_CYTO_RATE:    csr_prdata = 64'(cfg_ff.cyto_rate);
         REG_STORE_RATE:   csr_prdata = 64'(cfg_ff.store_rate);
         REG_BUFFER_TOTAL: csr_prdata = 64'(cfg_ff.buffer_total);
         REG_BUFFER_HALF:  csr_prdata = 64'(cfg_ff.buffer_half);
         REG_FLOOR:        csr_prdata = 64'(cfg_ff.floor_level);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{time_step:    '0,
                     cyto_rate:    '0,
                     store_rate:   '0,
                     buffer_total: '0,
                     buffer_half:  '0,
                     floor_level:  FLOOR_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ldss_window #(
      .ROW_LEN  (ROW_LEN),
      .NUM_ROWS (NUM_ROWS)
   ) u_window (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_cyto_conc  (req_cyto_conc),
      .req_store_conc (req_store_conc),
      .req_stall      (req_stall),
      .advance        (advance),
      .cell_task      (cell_task),
      .flushing       (win_flushing)
   );

   ldss_pipe u_pipe (
      .clock          (clock),
      .reset          (reset),
      .cell_task      (cell_task),
      .cfg            (cfg_ff),
      .advance        (advance),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cyto_next  (rsp_cyto_next),
      .rsp_store_next (rsp_store_next),
      .rsp_run_last   (rsp_run_last),
      .rsp_frame_done (rsp_frame_done)
   );

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> rsp_run_last)
      else $error("frame_done word without run_last");

   a_drain_stalls: assert property (@(posedge clock) disable iff (reset)
      win_flushing |-> req_stall)
      else $error("input taken while the last row drains");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result word straight after reset");

endmodule

`default_nettype wire

@@ dv/tb_lattice_diffusion_stencil_step_core.sv @@
`timescale 1ns / 1ps

module tb_lattice_diffusion_stencil_step_core;
   import ldss_pkg::*;

   localparam int ROW_LEN  = 16;
   localparam int NUM_ROWS = 16;
   localparam logic [63:0] MAX48 = 64'hFFFF_FFFF_FFFF;
   localparam int IDLE_LIMIT = 5000;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [CONC_W-1:0] req_cyto_conc;
   logic [CONC_W-1:0] req_store_conc;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [CONC_W-1:0] rsp_cyto_next;
   logic [CONC_W-1:0] rsp_store_next;
   logic              rsp_run_last;
   logic              rsp_frame_done;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [5:0]        csr_paddr;
   logic [63:0]       csr_pwdata;
   logic [63:0]       csr_prdata;
   logic              csr_pready;

   lattice_diffusion_stencil_step_core #(
      .ROW_LEN (ROW_LEN),
      .NUM_ROWS(NUM_ROWS)
   ) uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cyto_conc (req_cyto_conc),
      .req_store_conc(req_store_conc),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_cyto_next (rsp_cyto_next),
      .rsp_store_next(rsp_store_next),
      .rsp_run_last  (rsp_run_last),
      .rsp_frame_done(rsp_frame_done),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   // mirror of the block's registers and line stores
   logic [31:0]    m_time_step, m_cyto_rate, m_store_rate;
   logic [47:0]    m_buf_total, m_buf_half, m_floor;
   cell_type       row_recent [ROW_LEN];
   cell_type       row_older  [ROW_LEN];
   cell_type       left_cell;
   int unsigned    row_idx, col_idx;

   cell_type       pending_cells [$];
   result_type     expected_cells [$];

   int  errors;
   int  words_in, words_out, frames_seen;
   bit  quiet;
   bit  req_fire;
   int  req_gap, stall_left, idle_cycles;
   logic [47:0] level_base;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [63:0] buffering_factor(logic [47:0] c);
      logic [63:0]  s, x, d;
      logic [127:0] sq, q;
      s  = {16'd0, m_buf_half} + {16'd0, c};
      sq = {64'd0, s} * {64'd0, s};
      x  = sq[107:44];
      d  = x + {16'd0, m_buf_total};
      if (d == 64'd0) return 64'd1 << 32;
      q = ({64'd0, x} << 32) / {64'd0, d};
      return q[63:0];
   endfunction

   function automatic logic [47:0] diffuse_cell(logic [47:0] ctr, logic [63:0] sum,
                                                logic [63:0] n, logic [63:0] gain);
      logic [63:0]  base, mag, delta, r;
      logic [127:0] prod;
      bit           up;
      base  = n * {16'd0, ctr};
      up    = sum >= base;
      mag   = up ? sum - base : base - sum;
      prod  = {64'd0, mag} * {64'd0, gain};
      delta = prod[120:57];
      if (up) begin
         r = {16'd0, ctr} + delta;
         if (r > MAX48) r = MAX48;
      end else begin
         r = (delta >= {16'd0, ctr}) ? 64'd0 : {16'd0, ctr} - delta;
      end
      if (r < {16'd0, m_floor}) r = {16'd0, m_floor};
      return r[47:0];
   endfunction

   function automatic void add_expected(cell_type ctr, cell_type up, bit hu,
                                        cell_type dn, bit hd, cell_type lf, bit hl,
                                        cell_type rt, bit hr, bit last, bit done);
      logic [63:0]  sc, ss, n, pc, ps;
      logic [127:0] g;
      result_type   res;
      sc = 0; ss = 0; n = 0;
      pc = {32'd0, m_time_step} * {32'd0, m_cyto_rate};
      ps = {32'd0, m_time_step} * {32'd0, m_store_rate};
      g  = {64'd0, pc} * {64'd0, buffering_factor(ctr.cy)};
      if (hu) begin sc += up.cy; ss += up.st; n++; end
      if (hd) begin sc += dn.cy; ss += dn.st; n++; end
      if (hl) begin sc += lf.cy; ss += lf.st; n++; end
      if (hr) begin sc += rt.cy; ss += rt.st; n++; end
      res.cyto  = diffuse_cell(ctr.cy, sc, n, g[95:32]);
      res.store = diffuse_cell(ctr.st, ss, n, ps);
      res.last  = last;
      res.done  = done;
      expected_cells.push_back(res);
   endfunction

   function automatic void advance_grid(cell_type x);
      cell_type    none, rt, lf;
      bit          last_word;
      int unsigned r, c;
      none = '0;
      r = row_idx;
      c = col_idx;
      last_word = (r == NUM_ROWS - 1) && (c == ROW_LEN - 1);
      if (r >= 1) begin
         rt = (c + 1 < ROW_LEN) ? row_recent[c + 1] : none;
         add_expected(row_recent[c], row_older[c], r >= 2, x, 1'b1,
                      left_cell, c > 0, rt, c + 1 < ROW_LEN, !last_word, 1'b0);
      end
      left_cell     = row_recent[c];
      row_older[c]  = row_recent[c];
      row_recent[c] = x;
      if (last_word) begin
         for (int j = 0; j < ROW_LEN; j++) begin
            lf = (j > 0) ? row_recent[j - 1] : none;
            rt = (j + 1 < ROW_LEN) ? row_recent[j + 1] : none;
            add_expected(row_recent[j], row_older[j], 1'b1, none, 1'b0,
                         lf, j > 0, rt, j + 1 < ROW_LEN,
                         j == ROW_LEN - 1, j == ROW_LEN - 1);
         end
         row_idx = 0;
         col_idx = 0;
      end else if (c + 1 >= ROW_LEN) begin
         col_idx = 0;
         row_idx = r + 1;
      end else begin
         col_idx = c + 1;
      end
   endfunction

   // accept input words and update the prediction
   always @(posedge clock) begin
      req_fire = 1'b0;
      if (!reset && req_valid && !req_stall) begin
         cell_type x;
         x.cy = req_cyto_conc;
         x.st = req_store_conc;
         advance_grid(x);
         words_in++;
         req_fire = 1'b1;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_cells.size() > 0) begin
            cell_type x;
            x = pending_cells.pop_front();
            req_valid      <= 1'b1;
            req_cyto_conc  <= x.cy;
            req_store_conc <= x.st;
            req_gap = gap_len();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         stall_left = gap_len();
      end
   end

   // compare results against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         words_out++;
         if (rsp_frame_done) frames_seen++;
         if (expected_cells.size() == 0) begin
            $display("%0t: unexpected result cyto=%h store=%h", $time,
                     rsp_cyto_next, rsp_store_next);
            errors++;
         end else begin
            result_type e;
            e = expected_cells.pop_front();
            if (rsp_cyto_next !== e.cyto) begin
               $display("%0t: cyto_next expected %h got %h", $time, e.cyto, rsp_cyto_next);
               errors++;
            end
            if (rsp_store_next !== e.store) begin
               $display("%0t: store_next expected %h got %h", $time, e.store,
                        rsp_store_next);
               errors++;
            end
            if (rsp_run_last !== e.last) begin
               $display("%0t: run_last expected %b got %b", $time, e.last, rsp_run_last);
               errors++;
            end
            if (rsp_frame_done !== e.done) begin
               $display("%0t: frame_done expected %b got %b", $time, e.done,
                        rsp_frame_done);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: watchdog expired, %0d results outstanding", $time,
                  expected_cells.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic csr_write(csr_index_type idx, logic [63:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_TIME_STEP:    m_time_step  = value[31:0];
         REG_CYTO_RATE:    m_cyto_rate  = value[31:0];
         REG_STORE_RATE:   m_store_rate = value[31:0];
         REG_BUFFER_TOTAL: m_buf_total  = value[47:0];
         REG_BUFFER_HALF:  m_buf_half   = value[47:0];
         REG_FLOOR:        m_floor      = value[47:0];
         default: ;
      endcase
   endtask

   task automatic configure(logic [31:0] ts, logic [31:0] cr, logic [31:0] sr,
                            logic [47:0] bt, logic [47:0] bh, logic [47:0] fl);
      csr_write(REG_TIME_STEP, {32'd0, ts});
      csr_write(REG_CYTO_RATE, {32'd0, cr});
      csr_write(REG_STORE_RATE, {32'd0, sr});
      csr_write(REG_BUFFER_TOTAL, {16'd0, bt});
      csr_write(REG_BUFFER_HALF, {16'd0, bh});
      csr_write(REG_FLOOR, {16'd0, fl});
   endtask

   task automatic settle();
      while (pending_cells.size() > 0 || expected_cells.size() > 0 || req_valid)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   function automatic logic [47:0] rand48();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [47:0] pick_conc();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return MAX48[47:0];
         2:       return $urandom_range(0, 5000);
         3, 4, 5: return rand48();
         default: return level_base + $urandom_range(0, 1 << 20) - (1 << 19);
      endcase
   endfunction

   task automatic queue_random(int count);
      cell_type x;
      level_base = rand48() >> $urandom_range(0, 8);
      for (int i = 0; i < count; i++) begin
         x.cy = pick_conc();
         x.st = pick_conc();
         pending_cells.push_back(x);
      end
   endtask

   task automatic queue_directed();
      logic [47:0] pat [8];
      cell_type    x;
      pat = '{48'h0, 48'hFFFF_FFFF_FFFF, 48'h1, 48'h8000_0000_0000,
              48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 48'h0000_0000_06DF,
              48'h1000_0000_0000};
      for (int i = 0; i < 24; i++) begin
         x.cy = pat[i % 8];
         x.st = pat[(i * 3 + 1) % 8];
         pending_cells.push_back(x);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_cyto_conc = '0;
      req_store_conc = '0;
      rsp_stall = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      errors = 0; words_in = 0; words_out = 0; frames_seen = 0;
      quiet = 1'b0; req_fire = 1'b0; req_gap = 0; stall_left = 0; idle_cycles = 0;
      m_time_step = 0; m_cyto_rate = 0; m_store_rate = 0;
      m_buf_total = 0; m_buf_half = 0; m_floor = FLOOR_RESET;
      row_idx = 0; col_idx = 0; left_cell = '0;
      for (int j = 0; j < ROW_LEN; j++) begin
         row_recent[j] = '0;
         row_older[j]  = '0;
      end
      level_base = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      queue_directed();
      settle();

      configure('1, '1, '1, MAX48[47:0], MAX48[47:0], '0);
      queue_random(40);
      settle();

      quiet = 1'b1;
      configure(32'h0199_999A, 32'h1000_0000, 32'h0400_0000,
                rand48() >> 8, rand48() >> 4, FLOOR_RESET);
      queue_random(80);
      settle();
      quiet = 1'b0;

      configure($urandom(), $urandom(), $urandom(), '0, '0, '0);
      queue_random(50);
      settle();

      configure($urandom(), $urandom(), $urandom(), rand48(), rand48(), MAX48[47:0]);
      queue_random(30);
      settle();

      configure($urandom(), $urandom(), $urandom(), rand48(), rand48(), rand48() >> 20);
      queue_random(70);
      settle();

      configure('0, $urandom(), $urandom(), rand48(), rand48(), $urandom_range(0, 9999));
      queue_random(76);
      settle();

      repeat (100) @(posedge clock);
      $display("Covered %0d input words, %0d results, %0d completed frames", words_in,
               words_out, frames_seen);
      $display("over seven register settings including all-zero and all-ones extremes.");
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
